// ----- hdl/upc_pkg.sv -----
package upc_pkg;

    typedef enum logic [2:0] {
        S_HEAD,
        S_START,
        S_DATA,
        S_MID,
        S_CHECK,
        S_END
    } t_phase;

    typedef struct packed {
        logic [3:0] digit;
        logic       rev;
        logic       right;
        logic       start_g;
        logic       mid_g;
        logic       end_g;
        logic [3:0] check;
    } t_job;

    localparam logic [3:0] LAST_POS   = 4'd10;
    localparam logic [3:0] MID_POS    = 4'd5;
    localparam logic [3:0] LEFT_COUNT = 4'd6;
    localparam logic [3:0] RADIX      = 4'd10;

    localparam logic [2:0] GUARD_WIDTH = 3'd1;
    localparam logic [2:0] SIDE_LEN    = 3'd3;
    localparam logic [2:0] DIGIT_LEN   = 3'd4;
    localparam logic [2:0] MID_LEN     = 3'd5;

    function automatic logic [3:0] f_fold(input logic [3:0] v);
        f_fold = (v > 4'd9) ? v - RADIX : v;
    endfunction

    // Odd-parity widths, element 0 in the lowest three bits.
    function automatic logic [11:0] f_odd_row(input logic [3:0] d);
        logic [11:0] row;
        begin
            case (d)
                4'd0:    row = {3'd1, 3'd1, 3'd2, 3'd3};
                4'd1:    row = {3'd1, 3'd2, 3'd2, 3'd2};
                4'd2:    row = {3'd2, 3'd2, 3'd1, 3'd2};
                4'd3:    row = {3'd1, 3'd1, 3'd4, 3'd1};
                4'd4:    row = {3'd2, 3'd3, 3'd1, 3'd1};
                4'd5:    row = {3'd1, 3'd3, 3'd2, 3'd1};
                4'd6:    row = {3'd4, 3'd1, 3'd1, 3'd1};
                4'd7:    row = {3'd2, 3'd1, 3'd3, 3'd1};
                4'd8:    row = {3'd3, 3'd1, 3'd2, 3'd1};
                4'd9:    row = {3'd2, 3'd1, 3'd1, 3'd3};
                default: row = {3'd1, 3'd1, 3'd2, 3'd3};
            endcase
            f_odd_row = row;
        end
    endfunction

    function automatic logic [2:0] f_odd_width(input logic [3:0] d, input logic [1:0] j);
        logic [11:0] row;
        logic [2:0]  w;
        begin
            row = f_odd_row(d);
            unique case (j)
                2'd0: w = row[2:0];
                2'd1: w = row[5:3];
                2'd2: w = row[8:6];
                2'd3: w = row[11:9];
            endcase
            f_odd_width = w;
        end
    endfunction

    // A set bit marks a left position that uses the reversed (even) pattern.
    function automatic logic [5:0] f_even_mask(input logic [3:0] lead);
        logic [5:0] m;
        begin
            case (lead)
                4'd1:    m = 6'h34;
                4'd2:    m = 6'h2C;
                4'd3:    m = 6'h1C;
                4'd4:    m = 6'h32;
                4'd5:    m = 6'h26;
                4'd6:    m = 6'h0E;
                4'd7:    m = 6'h2A;
                4'd8:    m = 6'h1A;
                4'd9:    m = 6'h16;
                default: m = 6'h00;
            endcase
            f_even_mask = m;
        end
    endfunction

    function automatic logic [2:0] f_phase_len(input t_phase p);
        logic [2:0] n;
        begin
            case (p)
                S_START: n = SIDE_LEN;
                S_DATA:  n = DIGIT_LEN;
                S_MID:   n = MID_LEN;
                S_CHECK: n = DIGIT_LEN;
                S_END:   n = SIDE_LEN;
                default: n = DIGIT_LEN;
            endcase
            f_phase_len = n;
        end
    endfunction

endpackage

// ----- hdl/upc_ean_symbol_encoder.sv -----
// The first element of a digit passes through the job queue and then the output stage.
// The single element sequencer of the back end emits one element per cycle while the
// output is not stalled.
// The front end takes a new digit every cycle while the job queue has room.
// Reset is synchronous and active low; it clears position, sum, leading digit,
// the queue and the output stage.
module upc_ean_symbol_encoder import upc_pkg::*; #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic [3:0] i_cfg_data,     // leading_digit
    input  logic       i_s_tvalid,
    output logic       o_s_tready,
    input  logic [7:0] i_s_tdata,      // [3:0] digit, [7:4] zero
    output logic       o_m_tvalid,
    input  logic       i_m_tready,
    output logic [7:0] o_m_tdata,      // [2:0] element_width, [6:3] check_value, [7] zero
    output logic [2:0] o_m_tuser,      // [0] is_bar, [1] in_guard, [2] run_last
    output logic       o_m_tlast       // symbol_last
);

    logic w_push;
    logic w_full;
    logic w_pop;
    logic w_qvalid;
    t_job w_in_job;
    t_job w_q_job;

    assign o_cfg_ready = 1'b1;

    upc_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .i_s_tvalid  (i_s_tvalid),
        .i_digit     (i_s_tdata[3:0]),
        .o_s_tready  (o_s_tready),
        .i_full      (w_full),
        .o_push      (w_push),
        .o_job       (w_in_job)
    );

    upc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_job   (w_in_job),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_valid (w_qvalid),
        .o_job   (w_q_job)
    );

    upc_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (w_qvalid),
        .i_job       (w_q_job),
        .o_pop       (w_pop),
        .i_m_tready  (i_m_tready),
        .o_m_tvalid  (o_m_tvalid),
        .o_m_tdata   (o_m_tdata),
        .o_m_tuser   (o_m_tuser),
        .o_m_tlast   (o_m_tlast)
    );

endmodule

// ----- hdl/upc_front.sv -----
module upc_front import upc_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_valid,
    input  logic [3:0] i_cfg_data,
    input  logic       i_s_tvalid,
    input  logic [3:0] i_digit,
    output logic       o_s_tready,
    input  logic       i_full,
    output logic       o_push,
    output t_job       o_job
);

    logic [3:0] r_pos, n_pos;
    logic [3:0] r_sum, n_sum;
    logic [3:0] r_lead;
    logic [3:0] w_d;
    logic [3:0] w_lead;
    logic [4:0] w_wd;
    logic [5:0] w_acc;
    logic [4:0] w_tot;
    logic [3:0] w_totm;
    logic [3:0] w_check;
    logic [5:0] w_mask;

    assign o_s_tready = !i_full;
    assign o_push     = i_s_tvalid && !i_full;

    assign w_d    = f_fold(i_digit);
    assign w_lead = f_fold(r_lead);
    assign w_mask = f_even_mask(w_lead);
    assign w_wd   = r_pos[0] ? {1'b0, w_d} : ({1'b0, w_d} + {w_d, 1'b0});
    assign w_acc  = {2'b00, r_sum} + {1'b0, w_wd};

    always_comb begin
        priority if (w_acc >= 6'd30) begin
            n_sum = 4'(w_acc - 6'd30);
        end else if (w_acc >= 6'd20) begin
            n_sum = 4'(w_acc - 6'd20);
        end else if (w_acc >= 6'd10) begin
            n_sum = 4'(w_acc - 6'd10);
        end else begin
            n_sum = w_acc[3:0];
        end
    end

    assign w_tot   = {1'b0, n_sum} + {1'b0, w_lead};
    assign w_totm  = (w_tot >= 5'd10) ? 4'(w_tot - 5'd10) : w_tot[3:0];
    assign w_check = (w_totm == 4'd0) ? 4'd0 : RADIX - w_totm;

    always_comb begin
        o_job.digit   = w_d;
        o_job.rev     = (r_pos < LEFT_COUNT) ? w_mask[r_pos[2:0]] : 1'b0;
        o_job.right   = (r_pos >= LEFT_COUNT);
        o_job.start_g = (r_pos == 4'd0);
        o_job.mid_g   = (r_pos == MID_POS);
        o_job.end_g   = (r_pos == LAST_POS);
        o_job.check   = w_check;
    end

    assign n_pos = (r_pos >= LAST_POS) ? 4'd0 : r_pos + 4'd1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos  <= 4'd0;
            r_sum  <= 4'd0;
            r_lead <= 4'd0;
        end else begin
            if (i_cfg_valid) begin
                r_lead <= i_cfg_data;
            end
            if (o_push) begin
                r_pos <= n_pos;
                r_sum <= (r_pos >= LAST_POS) ? 4'd0 : n_sum;
            end
        end
    end

endmodule

// ----- hdl/upc_queue.sv -----
module upc_queue import upc_pkg::*; #(
    parameter int DEPTH = 2
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_job,
    output logic o_full,
    input  logic i_pop,
    output logic o_valid,
    output t_job o_job
);

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_IDX = PW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    t_job          r_q [DEPTH];
    logic [PW-1:0] r_wr, r_rd;
    logic [CW-1:0] r_cnt;

    assign o_full  = (r_cnt == FULL_CNT);
    assign o_valid = (r_cnt != '0);
    assign o_job   = r_q[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_q[r_wr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == LAST_IDX) ? '0 : r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= (r_rd == LAST_IDX) ? '0 : r_rd + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

// ----- hdl/upc_back.sv -----
module upc_back import upc_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_job_valid,
    input  t_job       i_job,
    output logic       o_pop,
    input  logic       i_m_tready,
    output logic       o_m_tvalid,
    output logic [7:0] o_m_tdata,
    output logic [2:0] o_m_tuser,
    output logic       o_m_tlast
);

    t_phase     r_ph, n_ph;
    logic [2:0] r_cnt, n_cnt;
    t_phase     w_eff;
    logic       w_plast;
    logic       w_jlast;
    logic       w_adv;
    logic [2:0] w_width;
    logic       w_bar;
    logic       w_guard;
    logic       w_slast;
    logic [1:0] w_j;

    logic       r_valid;
    logic [2:0] r_width;
    logic       r_bar;
    logic       r_guard;
    logic       r_rlast;
    logic       r_slast;
    logic [3:0] r_check;

    assign w_eff   = (r_ph == S_HEAD) ? (i_job.start_g ? S_START : S_DATA) : r_ph;
    assign w_plast = (r_cnt == f_phase_len(w_eff) - 3'd1);
    assign w_jlast = w_plast && ((w_eff == S_DATA && !i_job.mid_g && !i_job.end_g)
                                 || w_eff == S_MID || w_eff == S_END);
    assign w_slast = w_plast && (w_eff == S_END);
    assign w_adv   = i_job_valid && (!r_valid || i_m_tready);
    assign o_pop   = w_adv && w_jlast;

    always_comb begin
        n_ph  = r_ph;
        n_cnt = r_cnt;
        if (w_adv) begin
            if (!w_plast) begin
                n_ph  = w_eff;
                n_cnt = r_cnt + 3'd1;
            end else begin
                n_cnt = 3'd0;
                case (w_eff)
                    S_START: n_ph = S_DATA;
                    S_DATA:  n_ph = i_job.mid_g ? S_MID : (i_job.end_g ? S_CHECK : S_HEAD);
                    S_CHECK: n_ph = S_END;
                    default: n_ph = S_HEAD;
                endcase
            end
        end
    end

    always_comb begin
        w_j     = (i_job.rev && w_eff == S_DATA) ? 2'd3 - r_cnt[1:0] : r_cnt[1:0];
        w_width = GUARD_WIDTH;
        w_bar   = ~r_cnt[0];
        w_guard = 1'b1;
        case (w_eff)
            S_MID: begin
                w_bar = r_cnt[0];
            end
            S_DATA: begin
                w_width = f_odd_width(i_job.digit, w_j);
                w_bar   = r_cnt[0] ^ i_job.right;
                w_guard = 1'b0;
            end
            S_CHECK: begin
                w_width = f_odd_width(i_job.check, w_j);
                w_guard = 1'b0;
            end
            default: begin
                w_bar = ~r_cnt[0];
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ph    <= S_HEAD;
            r_cnt   <= 3'd0;
            r_valid <= 1'b0;
        end else begin
            r_ph  <= n_ph;
            r_cnt <= n_cnt;
            if (w_adv) begin
                r_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_width <= w_width;
            r_bar   <= w_bar;
            r_guard <= w_guard;
            r_rlast <= w_jlast;
            r_slast <= w_slast;
            r_check <= w_slast ? i_job.check : 4'd0;
        end
    end

    assign o_m_tvalid = r_valid;
    assign o_m_tdata  = {1'b0, r_check, r_width};
    assign o_m_tuser  = {r_rlast, r_guard, r_bar};
    assign o_m_tlast  = r_slast;

endmodule

// ----- hdl/upc_chk.sv -----
module upc_chk (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_m_tvalid,
    input logic       i_m_tready,
    input logic [7:0] o_m_tdata,
    input logic [2:0] o_m_tuser,
    input logic       o_m_tlast
);

    // The end of a symbol always closes the run of its digit.
    a_symbol_ends_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tlast |-> o_m_tuser[2])
        else $error("symbol end without run end");

    // The check digit is shown only on the last element of a symbol.
    a_check_only_at_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !o_m_tlast |-> o_m_tdata[6:3] == 4'd0)
        else $error("check digit outside symbol end");

    // Guard elements are one module wide; every element is one to four modules.
    a_width_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (o_m_tdata[2:0] != 3'd0) && (o_m_tdata[2:0] <= 3'd4)
                       && (!o_m_tuser[1] || o_m_tdata[2:0] == 3'd1))
        else $error("element width out of range");

    // A stalled transfer holds its contents.
    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata)
                                      && $stable(o_m_tuser) && $stable(o_m_tlast))
        else $error("output changed while stalled");

endmodule

bind upc_ean_symbol_encoder upc_chk u_chk (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata),
    .o_m_tuser  (o_m_tuser),
    .o_m_tlast  (o_m_tlast)
);

// ----- verif/testbench.sv -----
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int HOLD_CYCLES   = 300;
    localparam int STALL_LIMIT   = 5000;
    localparam int SETTLE_CYCLES = 20;
    localparam int PHASE_COUNT   = 8;

    typedef struct packed {
        logic [2:0] width;
        logic       bar;
        logic       guard;
        logic       run_end;
        logic       symbol_end;
        logic [3:0] check;
    } element_t;

    class element_tracker;
        logic [3:0] lead_digit = 4'd0;
        logic [3:0] position   = 4'd0;
        logic [3:0] checksum   = 4'd0;
        int         errors     = 0;
        element_t   pending_elements[$];
        element_t   digit_elements[$];

        function int pending();
            return pending_elements.size();
        endfunction

        function logic [3:0] fold(logic [3:0] v);
            return (v > 4'd9) ? v - 4'd10 : v;
        endfunction

        // Four widths per digit, the first element in the highest nibble.
        function logic [15:0] widths_of(logic [3:0] d);
            case (d)
                4'd0:    return 16'h3211;
                4'd1:    return 16'h2221;
                4'd2:    return 16'h2122;
                4'd3:    return 16'h1411;
                4'd4:    return 16'h1132;
                4'd5:    return 16'h1231;
                4'd6:    return 16'h1114;
                4'd7:    return 16'h1312;
                4'd8:    return 16'h1213;
                default: return 16'h3112;
            endcase
        endfunction

        function logic [5:0] even_positions(logic [3:0] lead);
            case (lead)
                4'd1:    return 6'h34;
                4'd2:    return 6'h2C;
                4'd3:    return 6'h1C;
                4'd4:    return 6'h32;
                4'd5:    return 6'h26;
                4'd6:    return 6'h0E;
                4'd7:    return 6'h2A;
                4'd8:    return 6'h1A;
                4'd9:    return 6'h16;
                default: return 6'h00;
            endcase
        endfunction

        function void add(logic [2:0] w, logic bar, logic guard);
            element_t e;
            e       = '0;
            e.width = w;
            e.bar   = bar;
            e.guard = guard;
            digit_elements.push_back(e);
        endfunction

        function void add_guard(int count, logic first_bar);
            for (int i = 0; i < count; i++)
                add(3'd1, first_bar ^ i[0], 1'b1);
        endfunction

        function void add_digit(logic [3:0] d, logic reversed, logic first_bar);
            logic [15:0] row;
            int          j;
            row = widths_of(d);
            for (int i = 0; i < 4; i++) begin
                j = reversed ? 3 - i : i;
                add(3'(row >> (4 * (3 - j))), first_bar ^ i[0], 1'b0);
            end
        endfunction

        function void note_digit(logic [3:0] raw);
            logic [3:0] d;
            logic [3:0] lead;
            logic [3:0] check_digit;
            logic [5:0] mask;
            element_t   tail;
            int         total;
            d    = fold(raw);
            lead = fold(lead_digit);
            mask = even_positions(lead);
            digit_elements.delete();
            if (position == 4'd0)
                add_guard(3, 1'b1);
            if (position < 4'd6)
                add_digit(d, mask[position[2:0]], 1'b0);
            else
                add_digit(d, 1'b0, 1'b1);
            checksum = 4'((int'(checksum) + (position[0] ? 1 : 3) * int'(d)) % 10);
            if (position == 4'd5)
                add_guard(5, 1'b0);
            if (position == 4'd10) begin
                total       = (int'(checksum) + int'(lead)) % 10;
                check_digit = 4'((10 - total) % 10);
                add_digit(check_digit, 1'b0, 1'b1);
                add_guard(3, 1'b1);
                tail            = digit_elements.pop_back();
                tail.symbol_end = 1'b1;
                tail.check      = check_digit;
                digit_elements.push_back(tail);
                position = 4'd0;
                checksum = 4'd0;
            end else begin
                position = position + 4'd1;
            end
            tail         = digit_elements.pop_back();
            tail.run_end = 1'b1;
            digit_elements.push_back(tail);
            foreach (digit_elements[i])
                pending_elements.push_back(digit_elements[i]);
        endfunction

        function void compare_field(string field, int want, int got);
            if (want != got) begin
                errors++;
                $display("%0t: %s expected %0d, got %0d", $time, field, want, got);
            end
        endfunction

        function void check_element(element_t got);
            element_t want;
            if (pending_elements.size() == 0) begin
                errors++;
                $display("%0t: element with nothing expected, expected none, got %h",
                         $time, got);
                return;
            end
            want = pending_elements.pop_front();
            compare_field("element_width", int'(want.width), int'(got.width));
            compare_field("is_bar", int'(want.bar), int'(got.bar));
            compare_field("in_guard", int'(want.guard), int'(got.guard));
            compare_field("run_last", int'(want.run_end), int'(got.run_end));
            compare_field("symbol_last", int'(want.symbol_end), int'(got.symbol_end));
            compare_field("check_value", int'(want.check), int'(got.check));
        endfunction
    endclass

    logic       i_clk       = 1'b0;
    logic       i_rst_n     = 1'b0;
    logic       i_cfg_valid = 1'b0;
    logic [3:0] i_cfg_data  = 4'd0;
    logic       i_s_tvalid  = 1'b0;
    logic [7:0] i_s_tdata   = 8'd0;
    logic       i_m_tready  = 1'b0;
    logic       o_cfg_ready;
    logic       o_s_tready;
    logic       o_m_tvalid;
    logic [7:0] o_m_tdata;
    logic [2:0] o_m_tuser;
    logic       o_m_tlast;

    int             src_idle_pct  = 24;
    int             sink_idle_pct = 24;
    logic           hold_request  = 1'b0;
    element_tracker tracker       = new;

    logic [3:0] directed_digits [22] = '{
        4'd0, 4'd1, 4'd2, 4'd3, 4'd4, 4'd5, 4'd6, 4'd7, 4'd8, 4'd9, 4'd15,
        4'd10, 4'd11, 4'd12, 4'd13, 4'd14, 4'd9, 4'd9, 4'd0, 4'd5, 4'd15, 4'd3
    };
    logic [3:0] phase_leads [PHASE_COUNT] = '{
        4'd15, 4'd0, 4'd6, 4'd10, 4'd9, 4'd3, 4'd0, 4'd0
    };

    upc_ean_symbol_encoder u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tuser   (o_m_tuser),
        .o_m_tlast   (o_m_tlast)
    );

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        element_t got;
        int       stall_cycles;
        if (i_rst_n && i_cfg_valid && o_cfg_ready)
            tracker.lead_digit = i_cfg_data;
        if (i_rst_n && i_s_tvalid && o_s_tready)
            tracker.note_digit(i_s_tdata[3:0]);
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            got.width      = o_m_tdata[2:0];
            got.check      = o_m_tdata[6:3];
            got.bar        = o_m_tuser[0];
            got.guard      = o_m_tuser[1];
            got.run_end    = o_m_tuser[2];
            got.symbol_end = o_m_tlast;
            tracker.check_element(got);
        end
        if (i_rst_n && ((i_cfg_valid && o_cfg_ready) || (i_s_tvalid && o_s_tready) ||
                        (o_m_tvalid && i_m_tready)))
            stall_cycles = 0;
        else
            stall_cycles++;
        if (stall_cycles >= STALL_LIMIT) begin
            $display("testbench failed");
            $finish;
        end
    end

    initial begin : sink
        int hold_left;
        hold_left = 0;
        forever begin
            @(posedge i_clk);
            if (hold_request) begin
                hold_request = 1'b0;
                hold_left    = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                i_m_tready <= 1'b0;
                hold_left--;
            end else begin
                i_m_tready <= ($urandom_range(0, 99) >= sink_idle_pct);
            end
        end
    end

    task automatic send_digit(input logic [3:0] value);
        while ($urandom_range(0, 99) < src_idle_pct) begin
            i_s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= {4'd0, value};
        do @(posedge i_clk); while (!o_s_tready);
    endtask

    // The task waits for a clock edge first so that the last accepted digit is already noted.
    task automatic wait_until_drained();
        i_s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (tracker.pending() != 0)
            @(posedge i_clk);
        repeat (2) @(posedge i_clk);
    endtask

    task automatic write_lead(input logic [3:0] value);
        wait_until_drained();
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
    endtask

    initial begin
        int phase_items;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // The first symbol runs with the leading digit left at its reset value.
        for (int i = 0; i < 22; i++) begin
            if (i == 11)
                write_lead(4'd9);
            send_digit(directed_digits[i]);
        end

        phase_leads[6] = 4'($urandom_range(0, 15));
        phase_leads[7] = 4'($urandom_range(0, 15));
        for (int p = 0; p < PHASE_COUNT; p++) begin
            write_lead(phase_leads[p]);
            src_idle_pct  = (p == 2) ? 0 : 24;
            sink_idle_pct = (p == 2) ? 0 : 24;
            if (p == 4)
                hold_request = 1'b1;
            phase_items = int'($urandom_range(18, 28));
            for (int n = 0; n < phase_items; n++) begin
                if ($urandom_range(0, 99) < 12)
                    send_digit(4'($urandom_range(10, 15)));
                else
                    send_digit(4'($urandom_range(0, 9)));
            end
            if (p == 5)
                wait_until_drained();
        end

        wait_until_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (tracker.errors == 0 && tracker.pending() == 0)
            $display("testbench passed");
        else
            $display("testbench failed");
        $finish;
    end
endmodule

// ----- sim.f -----
hdl/upc_pkg.sv
hdl/upc_front.sv
hdl/upc_queue.sv
hdl/upc_back.sv
hdl/upc_ean_symbol_encoder.sv
hdl/upc_chk.sv
verif/testbench.sv
